// ----- rtl/ssrd_pkg.sv -----
// Shared types, constants and the seven-segment character table for the
// seven-segment reading decoder. No dependencies.
package ssrd_pkg;

   localparam int unsigned PACKET_BYTES = 9;
   localparam int unsigned DISPLAY_END  = 7;
   localparam int unsigned MINUS_BIT    = 0;

   localparam logic [19:0] ACC_MAX      = 20'd999999;
   localparam logic [2:0]  FRAC_MAX     = 3'd7;
   localparam logic [3:0]  POS_MAX      = 4'd15;

   localparam logic [6:0] CHAR_SPACE  = 7'h20;
   localparam logic [6:0] CHAR_ZERO   = 7'h30;
   localparam logic [6:0] CHAR_NINE   = 7'h39;
   localparam logic [6:0] CHAR_LOW_A  = 7'h61;
   localparam logic [6:0] CHAR_LOW_Z  = 7'h7A;
   localparam logic [6:0] CASE_OFFSET = 7'h20;

   // Segment pattern (decimal point removed, 7 bits) to ASCII.
   localparam logic [6:0] SEG_ROM [0:127] = '{
      7'h20, 7'h27, 7'h69, 7'h49, 7'h5E, 7'h2A, 7'h2A, 7'h54,
      7'h2D, 7'h2A, 7'h72, 7'h66, 7'h2A, 7'h2A, 7'h2A, 7'h46,
      7'h5F, 7'h2A, 7'h65, 7'h4C, 7'h2A, 7'h2A, 7'h2A, 7'h43,
      7'h3D, 7'h2A, 7'h63, 7'h74, 7'h58, 7'h2A, 7'h67, 7'h45,
      7'h27, 7'h22, 7'h2A, 7'h2A, 7'h3F, 7'h2A, 7'h2A, 7'h2A,
      7'h2A, 7'h2A, 7'h2F, 7'h2A, 7'h2A, 7'h2A, 7'h2A, 7'h50,
      7'h2A, 7'h2A, 7'h2A, 7'h2A, 7'h2A, 7'h4D, 7'h2A, 7'h2A,
      7'h2A, 7'h59, 7'h2A, 7'h40, 7'h2A, 7'h51, 7'h32, 7'h52,
      7'h69, 7'h2A, 7'h2A, 7'h2A, 7'h2A, 7'h2A, 7'h2A, 7'h2A,
      7'h2A, 7'h5C, 7'h6E, 7'h68, 7'h2A, 7'h2A, 7'h2A, 7'h4B,
      7'h6A, 7'h2A, 7'h75, 7'h2A, 7'h20, 7'h2A, 7'h57, 7'h47,
      7'h61, 7'h2A, 7'h6F, 7'h62, 7'h2A, 7'h35, 7'h2A, 7'h36,
      7'h31, 7'h2A, 7'h2A, 7'h2A, 7'h37, 7'h37, 7'h37, 7'h4E,
      7'h2A, 7'h34, 7'h2A, 7'h48, 7'h2A, 7'h39, 7'h2A, 7'h41,
      7'h4A, 7'h56, 7'h4A, 7'h55, 7'h44, 7'h2A, 7'h2A, 7'h30,
      7'h2A, 7'h79, 7'h64, 7'h26, 7'h33, 7'h39, 7'h61, 7'h38
   };

   // Overrange text "  0L  " and calibration text " CAL".
   localparam logic [6:0] OVR_TEXT [0:5] = '{7'h20, 7'h20, 7'h30, 7'h4C, 7'h20, 7'h20};
   localparam logic [6:0] CAL_TEXT [0:3] = '{7'h20, 7'h43, 7'h41, 7'h4C};

   typedef struct packed {
      logic [6:0] char_code;
      logic       point;
      logic       is_digit;
      logic       is_space;
      logic [3:0] digit_value;
   } ssrd_char_type;

   typedef struct packed {
      logic               negative;
      logic [2:0]         fraction_digits;
      logic signed [20:0] reading_digits;
      logic               is_cal;
      logic               is_overrange;
      logic               is_numeric;
      logic               packet_complete;
      logic               point_here;
      logic [6:0]         char_code;
      logic [3:0]         byte_position;
   } ssrd_result_type;

   function automatic logic [6:0] upper_char(input logic [6:0] c);
      logic [6:0] r;
      r = c;
      if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

// ----- rtl/ssrd_char_decode.sv -----
// Seven-segment byte to character decode and character classification.
// Depends on ssrd_pkg (SEG_ROM, ssrd_char_type).
module ssrd_char_decode (
   input  logic [7:0]             packet_byte,
   output ssrd_pkg::ssrd_char_type char_info
);

   logic [6:0] seg_index;
   logic [6:0] char_code;
   logic [6:0] digit_offset;

   // Drop the decimal point bit and pack the rest.
   assign seg_index    = {packet_byte[7:3], packet_byte[1:0]};
   assign char_code    = ssrd_pkg::SEG_ROM[seg_index];
   assign digit_offset = char_code - ssrd_pkg::CHAR_ZERO;

   always_comb begin
      char_info.char_code   = char_code;
      char_info.point       = packet_byte[2];
      char_info.is_digit    = (char_code >= ssrd_pkg::CHAR_ZERO) &&
                              (char_code <= ssrd_pkg::CHAR_NINE);
      char_info.is_space    = (char_code == ssrd_pkg::CHAR_SPACE);
      char_info.digit_value = digit_offset[3:0];
   end

endmodule

// ----- rtl/ssrd_reading_track.sv -----
// Per-packet parse state: sign, digit accumulator, point and text matches.
// Depends on ssrd_pkg (constants, ssrd_char_type, ssrd_result_type).
module ssrd_reading_track (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [7:0]                 packet_byte,
   input  logic                       end_of_packet,
   input  ssrd_pkg::ssrd_char_type    char_info,
   output ssrd_pkg::ssrd_result_type  result
);

   logic [3:0]  position_count_ff, position_count_in;
   logic        minus_seen_ff, minus_seen_in;
   logic        point_seen_ff, point_seen_in;
   logic        numeric_so_far_ff, numeric_so_far_in;
   logic [19:0] digit_accumulator_ff, digit_accumulator_in;
   logic        digits_started_ff, digits_started_in;
   logic        digits_ended_ff, digits_ended_in;
   logic [2:0]  fraction_count_ff, fraction_count_in;
   logic        overrange_match_ff, overrange_match_in;
   logic        cal_match_ff, cal_match_in;

   logic [3:0]  p;
   logic [2:0]  k;
   logic        is_display;
   logic [23:0] acc_times_ten;
   logic [3:0]  chars;
   logic [6:0]  ovr_char;
   logic [6:0]  cal_char;

   assign p             = position_count_ff;
   assign k             = 3'(p - 4'd1);
   assign is_display    = (p != 4'd0) && (p < 4'(ssrd_pkg::DISPLAY_END));
   assign acc_times_ten = {1'b0, digit_accumulator_ff, 3'b000} +
                          {3'b000, digit_accumulator_ff, 1'b0} +
                          {20'd0, char_info.digit_value};
   assign ovr_char      = (k < 3'd6) ? ssrd_pkg::OVR_TEXT[k] : ssrd_pkg::CHAR_SPACE;
   assign cal_char      = ssrd_pkg::CAL_TEXT[k[1:0]];

   always_comb begin
      minus_seen_in        = minus_seen_ff;
      point_seen_in        = point_seen_ff;
      numeric_so_far_in    = numeric_so_far_ff;
      digit_accumulator_in = digit_accumulator_ff;
      digits_started_in    = digits_started_ff;
      digits_ended_in      = digits_ended_ff;
      fraction_count_in    = fraction_count_ff;
      overrange_match_in   = overrange_match_ff;
      cal_match_in         = cal_match_ff;
      position_count_in    = position_count_ff;
      chars                = 4'd0;

      result                 = '0;
      result.byte_position   = p;

      if (p == 4'd0) begin
         minus_seen_in = packet_byte[ssrd_pkg::MINUS_BIT];
      end else if (is_display) begin
         result.char_code  = char_info.char_code;
         result.point_here = char_info.point;

         if (!char_info.is_digit && !char_info.is_space) begin
            numeric_so_far_in = 1'b0;
         end
         // Only the first decimal point counts.
         if (char_info.point && !point_seen_ff) begin
            overrange_match_in = 1'b0;
            if (k < 3'd4) begin
               cal_match_in = 1'b0;
            end
            point_seen_in = 1'b1;
         end
         if (k >= 3'd6 || ssrd_pkg::upper_char(char_info.char_code) != ovr_char) begin
            overrange_match_in = 1'b0;
         end
         if (k < 3'd4 && char_info.char_code != cal_char) begin
            cal_match_in = 1'b0;
         end
         if (char_info.is_digit && !digits_ended_ff) begin
            digits_started_in = 1'b1;
            if (acc_times_ten > {4'd0, ssrd_pkg::ACC_MAX}) begin
               digit_accumulator_in = ssrd_pkg::ACC_MAX;
            end else begin
               digit_accumulator_in = acc_times_ten[19:0];
            end
            if (point_seen_in && fraction_count_ff < ssrd_pkg::FRAC_MAX) begin
               fraction_count_in = fraction_count_ff + 3'd1;
            end
         end else if (char_info.is_space && !digits_ended_ff &&
                      (digits_started_ff || point_seen_in)) begin
            digits_ended_in = 1'b1;
         end
      end

      result.negative = minus_seen_in;

      if (end_of_packet) begin
         if (p != 4'd0) begin
            chars = is_display ? p : 4'(ssrd_pkg::DISPLAY_END - 1);
         end
         result.packet_complete = ({1'b0, p} + 5'd1) == 5'(ssrd_pkg::PACKET_BYTES);
         result.is_numeric      = numeric_so_far_in;
         if (numeric_so_far_in) begin
            result.reading_digits  = minus_seen_in ? -$signed({1'b0, digit_accumulator_in})
                                                   :  $signed({1'b0, digit_accumulator_in});
            result.fraction_digits = fraction_count_in;
         end else begin
            result.is_overrange = overrange_match_in && (chars == 4'd6) && !point_seen_in;
            result.is_cal       = cal_match_in && (chars >= 4'd4) && !minus_seen_in;
         end
         // Drop all parse state for the next packet.
         position_count_in    = 4'd0;
         minus_seen_in        = 1'b0;
         point_seen_in        = 1'b0;
         numeric_so_far_in    = 1'b1;
         digit_accumulator_in = 20'd0;
         digits_started_in    = 1'b0;
         digits_ended_in      = 1'b0;
         fraction_count_in    = 3'd0;
         overrange_match_in   = 1'b1;
         cal_match_in         = 1'b1;
      end else if (p < ssrd_pkg::POS_MAX) begin
         position_count_in = p + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_count_ff    <= 4'd0;
         minus_seen_ff        <= 1'b0;
         point_seen_ff        <= 1'b0;
         numeric_so_far_ff    <= 1'b1;
         digit_accumulator_ff <= 20'd0;
         digits_started_ff    <= 1'b0;
         digits_ended_ff      <= 1'b0;
         fraction_count_ff    <= 3'd0;
         overrange_match_ff   <= 1'b1;
         cal_match_ff         <= 1'b1;
      end else if (advance) begin
         position_count_ff    <= position_count_in;
         minus_seen_ff        <= minus_seen_in;
         point_seen_ff        <= point_seen_in;
         numeric_so_far_ff    <= numeric_so_far_in;
         digit_accumulator_ff <= digit_accumulator_in;
         digits_started_ff    <= digits_started_in;
         digits_ended_ff      <= digits_ended_in;
         fraction_count_ff    <= fraction_count_in;
         overrange_match_ff   <= overrange_match_in;
         cal_match_ff         <= cal_match_in;
      end
   end

endmodule

// ----- rtl/seven_segment_reading_decoder_unit.sv -----
// Top level of the seven-segment reading decoder: input register, decode
// and parse logic, result register. Depends on ssrd_pkg, ssrd_char_decode
// and ssrd_reading_track.
//
// Feed the bytes of one meter display packet on the req_ stream, byte 0
// (minus annunciator) first, and mark the packet's final byte with
// req_tlast. Every byte gives one transfer on the rsp_ stream, by way of the
// input register and then the result register: the byte position, the
// decoded ASCII character and the decimal point of display bytes 1 to 6,
// and the minus flag. The result of the tlast byte also carries the packet
// summary (complete, numeric, overrange, calibration, signed digit value
// and fraction digit count); these fields read zero on all other results.
// The block takes one byte per cycle while the result side is not stalled;
// that rate rests on the parse update (table lookup plus a multiply-by-ten
// accumulate) being combinational between the input register and the
// result register. The result register lets a new byte enter while the
// previous result waits to be taken. Reset clears the parse state, so a
// packet cut short by reset starts fresh.
module seven_segment_reading_decoder_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] packet_byte
   input  logic        req_tlast,   // end_of_packet

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] byte_position, [10:4] char_code, [11] point_here,
   // [12] packet_complete, [13] is_numeric, [14] is_overrange, [15] is_cal,
   // [36:16] reading_digits, [39:37] fraction_digits, [40] negative,
   // [47:41] zero
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast    // last_of_packet
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   ssrd_pkg::ssrd_result_type rsp_data_ff;
   logic                      rsp_last_ff;

   logic                      advance;
   logic                      req_take;
   ssrd_pkg::ssrd_char_type   char_info;
   ssrd_pkg::ssrd_result_type result;

   // Move the held byte into the result register when that slot is free
   // or being emptied this cycle.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: hold the byte on each transfer, load the result on advance.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         rsp_data_ff <= result;
         rsp_last_ff <= in_last_ff;
      end
   end

   ssrd_char_decode u_char_decode (
      .packet_byte (in_byte_ff),
      .char_info   (char_info)
   );

   ssrd_reading_track u_reading_track (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .packet_byte   (in_byte_ff),
      .end_of_packet (in_last_ff),
      .char_info     (char_info),
      .result        (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

endmodule

// ----- rtl/ssrd_checker.sv -----
// Port-level checks for seven_segment_reading_decoder_unit, bound to it.
// Depends only on the top level's ports.
module ssrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // No result right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Summary fields are zero except on the packet's last result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[39:12] == 28'd0)
      else $error("summary fields set on a non-final result");

   // A non-numeric packet reports no value and no fraction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast && !rsp_tdata[13] |-> rsp_tdata[39:16] == 24'd0)
      else $error("value reported for non-numeric packet");

   // Overrange and calibration exclude a numeric reading.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[13] && (rsp_tdata[14] || rsp_tdata[15])))
      else $error("numeric packet flagged overrange or calibration");

endmodule

bind seven_segment_reading_decoder_unit ssrd_checker u_ssrd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
